/* rtl/core/sme_pkg.sv */
`default_nettype none
package sme_pkg;

  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int ADDR_W   = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_WORDS_DEF  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_ADD  = 3'd2,
    OP_MULT = 3'd3,
    OP_END  = 3'd4,
    OP_LOAD = 3'd5,
    OP_READ = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_HALTED    = 2'd3
  } status_t;

  typedef struct packed {
    logic    data_we;
    logic    stack_we;
    logic    halt;
    logic    is_read;
    status_t status;
  } step_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/sme_if.sv */
`default_nettype none
interface sme_instr_if;
  logic                               valid;
  logic                               ready;
  logic [sme_pkg::OP_W-1:0]           operation;
  logic [sme_pkg::ADDR_W-1:0]         address;
  logic signed [sme_pkg::WORD_W-1:0]  load_value;

  modport source(output valid, operation, address, load_value, input ready);
  modport sink(input valid, operation, address, load_value, output ready);
endinterface

interface sme_result_if;
  logic                               valid;
  logic                               ready;
  logic [sme_pkg::STATUS_W-1:0]       status;
  logic signed [sme_pkg::WORD_W-1:0]  result_value;
  logic [sme_pkg::COUNT_W-1:0]        stack_count;

  modport source(output valid, status, result_value, stack_count, input ready);
  modport sink(input valid, status, result_value, stack_count, output ready);
endinterface
`default_nettype wire

/* rtl/core/stack_machine_execute.sv */
// Zero-address stack machine, one instruction per request.
// instr (sink): operation, address, load_value. result (source): status,
// result_value, stack_count; exactly one result per instruction, in order.
// A request is held in the instruction register while the data word it
// addresses is read from the data RAM, then executes and lands in the result
// register. Throughput is one instruction per cycle while the receiver does
// not stall. The top two stack entries live in registers; the third is
// prefetched from the stack RAM every cycle, with a bypass when it is written
// in the same cycle. The data RAM likewise bypasses a write from the
// executing instruction to the address being fetched. After reset,
// instr.ready stays low while the data RAM is swept to zero; stack depth and
// the halt flag clear at once.
// When the receiver stalls, the result register holds; one more instruction
// is taken into the instruction register, after which instr.ready drops.
// END or an unknown opcode halts the machine until reset; reads still work.
`default_nettype none
module stack_machine_execute #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WORDS  = sme_pkg::DATA_WORDS_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  sme_instr_if.sink    instr,
  sme_result_if.source result
);

  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int DW     = $clog2(STACK_DEPTH + 1);
  localparam int DAW    = $clog2(DATA_WORDS);
  localparam int NADDR  = 2 ** sme_pkg::ADDR_W;
  localparam int WORD_W = sme_pkg::WORD_W;

  logic [DAW-1:0] addr_map [NADDR];

  for (genvar i = 0; i < NADDR; i++) begin : g_addr_map
    localparam int IDX = i % DATA_WORDS;
    assign addr_map[i] = DAW'(IDX);
  end

  logic                     clr_active;
  logic [DAW-1:0]           clr_addr;

  logic                     a_valid;
  logic [sme_pkg::OP_W-1:0] a_op;
  logic [DAW-1:0]           a_addr;
  logic [WORD_W-1:0]        a_load_value;

  logic                     halted;
  logic [DW-1:0]            depth;
  logic [WORD_W-1:0]        tos;
  logic [WORD_W-1:0]        nos;

  logic                     third_byp;
  logic [WORD_W-1:0]        third_byp_data;
  logic                     data_byp;
  logic [WORD_W-1:0]        data_byp_data;

  logic                       rsp_valid;
  logic [sme_pkg::STATUS_W-1:0] rsp_status;
  logic [WORD_W-1:0]          rsp_value;
  logic [sme_pkg::COUNT_W-1:0] rsp_count;

  logic                     accept;
  logic                     exec;
  sme_pkg::step_ctl_t       ctl;
  logic [DW-1:0]            depth_next;
  logic [DW-1:0]            depth_upd;
  logic [WORD_W-1:0]        tos_next;
  logic [WORD_W-1:0]        nos_next;
  logic [WORD_W-1:0]        data_wdata;
  logic [WORD_W-1:0]        third;
  logic [WORD_W-1:0]        data_word;
  logic [WORD_W-1:0]        stack_rdata;
  logic [WORD_W-1:0]        data_rdata;

  logic                     stack_we;
  logic [SAW-1:0]           stack_waddr;
  logic [SAW-1:0]           stack_raddr;
  logic                     data_we;
  logic [DAW-1:0]           data_waddr;
  logic [WORD_W-1:0]        data_ram_wdata;
  logic [DAW-1:0]           data_raddr;

  assign exec         = a_valid && (!rsp_valid || result.ready);
  assign instr.ready  = !clr_active && (!a_valid || exec);
  assign accept       = instr.valid && instr.ready;

  assign result.valid        = rsp_valid;
  assign result.status       = rsp_status;
  assign result.result_value = rsp_value;
  assign result.stack_count  = rsp_count;

  assign third     = third_byp ? third_byp_data : stack_rdata;
  assign data_word = data_byp ? data_byp_data : data_rdata;

  sme_step #(
    .STACK_DEPTH(STACK_DEPTH),
    .DW         (DW)
  ) u_step (
    .op        (a_op),
    .halted    (halted),
    .depth     (depth),
    .tos       (tos),
    .nos       (nos),
    .third     (third),
    .data_word (data_word),
    .load_value(a_load_value),
    .ctl       (ctl),
    .depth_next(depth_next),
    .tos_next  (tos_next),
    .nos_next  (nos_next),
    .data_wdata(data_wdata)
  );

  // stack RAM holds entries below the two top registers
  assign depth_upd   = exec ? depth_next : depth;
  assign stack_we    = exec && ctl.stack_we;
  assign stack_waddr = SAW'(depth - DW'(2));
  assign stack_raddr = SAW'(depth_upd - DW'(3));

  sme_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stack_we),
    .waddr(stack_waddr),
    .wdata(nos),
    .re   (1'b1),
    .raddr(stack_raddr),
    .rdata(stack_rdata)
  );

  assign data_we        = clr_active || (exec && ctl.data_we);
  assign data_waddr     = clr_active ? clr_addr : a_addr;
  assign data_ram_wdata = clr_active ? '0 : data_wdata;
  assign data_raddr     = addr_map[instr.address];

  sme_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DATA_WORDS)
  ) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(data_waddr),
    .wdata(data_ram_wdata),
    .re   (accept),
    .raddr(data_raddr),
    .rdata(data_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == DAW'(DATA_WORDS - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + DAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (exec) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op          <= instr.operation;
      a_addr        <= data_raddr;
      a_load_value  <= instr.load_value;
      data_byp      <= exec && ctl.data_we && (a_addr == data_raddr);
      data_byp_data <= data_wdata;
    end
    third_byp      <= stack_we && (stack_waddr == stack_raddr);
    third_byp_data <= nos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
      depth  <= '0;
    end else if (exec) begin
      halted <= halted || ctl.halt;
      depth  <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      tos <= tos_next;
      nos <= nos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec) begin
      rsp_valid <= 1'b1;
    end else if (result.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp_status <= ctl.status;
      rsp_count  <= sme_pkg::COUNT_W'(depth_next);
      if (ctl.is_read) begin
        rsp_value <= data_word;
      end else if (depth_next == '0) begin
        rsp_value <= '0;
      end else begin
        rsp_value <= tos_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sme_ram.sv */
`default_nettype none
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sme_step.sv */
`default_nettype none
module sme_step #(
  parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int DW          = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic [sme_pkg::OP_W-1:0]   op,
  input  wire logic                       halted,
  input  wire logic [DW-1:0]              depth,
  input  wire logic [sme_pkg::WORD_W-1:0] tos,
  input  wire logic [sme_pkg::WORD_W-1:0] nos,
  input  wire logic [sme_pkg::WORD_W-1:0] third,
  input  wire logic [sme_pkg::WORD_W-1:0] data_word,
  input  wire logic [sme_pkg::WORD_W-1:0] load_value,
  output sme_pkg::step_ctl_t              ctl,
  output logic      [DW-1:0]              depth_next,
  output logic      [sme_pkg::WORD_W-1:0] tos_next,
  output logic      [sme_pkg::WORD_W-1:0] nos_next,
  output logic      [sme_pkg::WORD_W-1:0] data_wdata
);

  logic [sme_pkg::WORD_W-1:0]   sum;
  logic [2*sme_pkg::WORD_W-1:0] prod_full;

  assign sum        = nos + tos;
  assign prod_full  = nos * tos;
  assign data_wdata = (op == sme_pkg::OP_LOAD) ? load_value : tos;

  always_comb begin
    ctl        = '0;
    ctl.status = sme_pkg::ST_OK;
    depth_next = depth;
    tos_next   = tos;
    nos_next   = nos;
    if (halted) begin
      ctl.status  = sme_pkg::ST_HALTED;
      ctl.is_read = (op == sme_pkg::OP_READ);
    end else begin
      case (sme_pkg::op_t'(op))
        sme_pkg::OP_PUSH: begin
          if (depth == DW'(STACK_DEPTH)) begin
            ctl.status = sme_pkg::ST_OVERFLOW;
          end else begin
            depth_next   = depth + DW'(1);
            tos_next     = data_word;
            nos_next     = tos;
            ctl.stack_we = (depth >= DW'(2));
          end
        end
        sme_pkg::OP_POP: begin
          if (depth == '0) begin
            ctl.status = sme_pkg::ST_UNDERFLOW;
          end else begin
            depth_next  = depth - DW'(1);
            tos_next    = nos;
            nos_next    = third;
            ctl.data_we = 1'b1;
          end
        end
        sme_pkg::OP_ADD, sme_pkg::OP_MULT: begin
          if (depth < DW'(2)) begin
            ctl.status = sme_pkg::ST_UNDERFLOW;
          end else begin
            depth_next = depth - DW'(1);
            tos_next   = (op == sme_pkg::OP_ADD) ? sum : prod_full[sme_pkg::WORD_W-1:0];
            nos_next   = third;
          end
        end
        sme_pkg::OP_LOAD: begin
          ctl.data_we = 1'b1;
        end
        sme_pkg::OP_READ: begin
          ctl.is_read = 1'b1;
        end
        default: begin
          ctl.halt   = 1'b1;
          ctl.status = sme_pkg::ST_HALTED;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* dv/tb_stack_machine_execute.sv */
`default_nettype none
module tb_stack_machine_execute;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_STACK = sme_pkg::STACK_DEPTH_DEF;
  localparam int N_DATA  = sme_pkg::DATA_WORDS_DEF;
  localparam int N_RANDOM = 1000;
  localparam int N_DIRECTED = 25;
  localparam logic [sme_pkg::OP_W-1:0] OP_UNDEFINED = 3'd7;

  typedef struct packed {
    sme_pkg::status_t             st;
    logic [sme_pkg::WORD_W-1:0]   val;
    logic [sme_pkg::COUNT_W-1:0]  cnt;
  } step_result_t;

  typedef struct {
    logic [sme_pkg::OP_W-1:0]     op;
    logic [sme_pkg::ADDR_W-1:0]   addr;
    logic [sme_pkg::WORD_W-1:0]   lval;
    bit                           typed;
    sme_pkg::status_t             st;
    logic [sme_pkg::WORD_W-1:0]   val;
    logic [sme_pkg::COUNT_W-1:0]  cnt;
  } stim_row_t;

  // expected values typed in only for the rows that follow directly from reset
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{sme_pkg::OP_POP,  5'd0,  32'h0,         1'b1, sme_pkg::ST_UNDERFLOW, 32'h0, 7'd0},
    '{sme_pkg::OP_ADD,  5'd0,  32'h0,         1'b1, sme_pkg::ST_UNDERFLOW, 32'h0, 7'd0},
    '{sme_pkg::OP_MULT, 5'd0,  32'h0,         1'b1, sme_pkg::ST_UNDERFLOW, 32'h0, 7'd0},
    '{sme_pkg::OP_READ, 5'd31, 32'h0,         1'b1, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_LOAD, 5'd0,  32'h7FFF_FFFF, 1'b1, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_LOAD, 5'd31, 32'h8000_0000, 1'b1, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_LOAD, 5'd1,  32'hFFFF_FFFF, 1'b1, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_READ, 5'd0,  32'h0, 1'b1, sme_pkg::ST_OK,        32'h7FFF_FFFF, 7'd0},
    '{sme_pkg::OP_PUSH, 5'd0,  32'h0, 1'b1, sme_pkg::ST_OK,        32'h7FFF_FFFF, 7'd1},
    '{sme_pkg::OP_MULT, 5'd0,  32'h0, 1'b1, sme_pkg::ST_UNDERFLOW, 32'h7FFF_FFFF, 7'd1},
    '{sme_pkg::OP_PUSH, 5'd31, 32'h0, 1'b1, sme_pkg::ST_OK,        32'h8000_0000, 7'd2},
    '{sme_pkg::OP_ADD,  5'd0,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_PUSH, 5'd1,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_MULT, 5'd0,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_PUSH, 5'd0,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_ADD,  5'd0,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_PUSH, 5'd31, 32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_MULT, 5'd0,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_POP,  5'd5,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_READ, 5'd5,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_POP,  5'd2,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_LOAD, 5'd2,  32'h5A5A_A5A5, 1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_PUSH, 5'd2,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_POP,  5'd3,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0},
    '{sme_pkg::OP_READ, 5'd3,  32'h0,         1'b0, sme_pkg::ST_OK,        32'h0, 7'd0}
  };

  localparam sme_pkg::op_t LIVE_OPS [6] = '{sme_pkg::OP_PUSH, sme_pkg::OP_POP,
                                            sme_pkg::OP_ADD, sme_pkg::OP_MULT,
                                            sme_pkg::OP_LOAD, sme_pkg::OP_READ};
  localparam sme_pkg::op_t SHRINK_OPS [3] = '{sme_pkg::OP_POP, sme_pkg::OP_ADD,
                                              sme_pkg::OP_MULT};
  localparam logic [sme_pkg::WORD_W-1:0] EDGE_WORDS [5] =
    '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};

  logic clk = 1'b0;
  logic rst;

  sme_instr_if  instr_bus ();
  sme_result_if result_bus ();

  stack_machine_execute #(
    .STACK_DEPTH(N_STACK),
    .DATA_WORDS (N_DATA)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .instr (instr_bus),
    .result(result_bus)
  );

  always #4 clk = ~clk;

  // shadow copy of the machine state
  logic [sme_pkg::WORD_W-1:0] shadow_stack [N_STACK];
  logic [sme_pkg::WORD_W-1:0] shadow_data [N_DATA];
  int unsigned                shadow_depth;
  bit                         shadow_halted;

  step_result_t results_due [$];
  int unsigned  error_count;
  bit           send_burst;
  bit           recv_burst;

  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic step_result_t run_instruction(input logic [sme_pkg::OP_W-1:0] op,
                                                   input logic [sme_pkg::ADDR_W-1:0] addr,
                                                   input logic [sme_pkg::WORD_W-1:0] lval);
    step_result_t res;
    int unsigned  idx;
    bit           is_read;
    logic [sme_pkg::WORD_W-1:0] a;
    logic [sme_pkg::WORD_W-1:0] b;
    idx = addr % N_DATA;
    is_read = 1'b0;
    res.st = sme_pkg::ST_OK;
    if (shadow_halted) begin
      res.st = sme_pkg::ST_HALTED;
      is_read = (op == sme_pkg::OP_READ);
    end else begin
      case (op)
        sme_pkg::OP_PUSH: begin
          if (shadow_depth >= N_STACK) begin
            res.st = sme_pkg::ST_OVERFLOW;
          end else begin
            shadow_stack[shadow_depth] = shadow_data[idx];
            shadow_depth++;
          end
        end
        sme_pkg::OP_POP: begin
          if (shadow_depth == 0) begin
            res.st = sme_pkg::ST_UNDERFLOW;
          end else begin
            shadow_depth--;
            shadow_data[idx] = shadow_stack[shadow_depth];
          end
        end
        sme_pkg::OP_ADD, sme_pkg::OP_MULT: begin
          if (shadow_depth < 2) begin
            res.st = sme_pkg::ST_UNDERFLOW;
          end else begin
            a = shadow_stack[shadow_depth-2];
            b = shadow_stack[shadow_depth-1];
            shadow_depth--;
            shadow_stack[shadow_depth-1] = (op == sme_pkg::OP_ADD) ? a + b : a * b;
          end
        end
        sme_pkg::OP_LOAD: shadow_data[idx] = lval;
        sme_pkg::OP_READ: is_read = 1'b1;
        default: begin
          shadow_halted = 1'b1;
          res.st = sme_pkg::ST_HALTED;
        end
      endcase
    end
    if (is_read) res.val = shadow_data[idx];
    else if (shadow_depth == 0) res.val = '0;
    else res.val = shadow_stack[shadow_depth-1];
    res.cnt = sme_pkg::COUNT_W'(shadow_depth);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [sme_pkg::WORD_W-1:0] got,
                                 input logic [sme_pkg::WORD_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_instruction(input logic [sme_pkg::OP_W-1:0] op,
                                  input logic [sme_pkg::ADDR_W-1:0] addr,
                                  input logic [sme_pkg::WORD_W-1:0] lval, input bit typed,
                                  input step_result_t typed_res);
    int unsigned  gap;
    step_result_t predicted;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      instr_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_bus.valid      <= 1'b1;
    instr_bus.operation  <= op;
    instr_bus.address    <= addr;
    instr_bus.load_value <= lval;
    do @(posedge clk); while (instr_bus.ready !== 1'b1);
    predicted = run_instruction(op, addr, lval);
    results_due.push_back(typed ? typed_res : predicted);
  endtask

  function automatic logic [sme_pkg::WORD_W-1:0] draw_word();
    if ($urandom_range(0, 4) == 0) return EDGE_WORDS[$urandom_range(0, 4)];
    return $urandom;
  endfunction

  function automatic logic [sme_pkg::ADDR_W-1:0] draw_addr();
    if ($urandom_range(0, 1) == 0) return sme_pkg::ADDR_W'($urandom_range(0, 3));
    return sme_pkg::ADDR_W'($urandom_range(0, N_DATA-1));
  endfunction

  // result checker
  always @(posedge clk) begin
    step_result_t want;
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", result_bus.result_value, '0);
      end else begin
        want = results_due.pop_front();
        if (result_bus.status !== want.st)
          report_mismatch("status", sme_pkg::WORD_W'(result_bus.status),
                          sme_pkg::WORD_W'(want.st));
        if (result_bus.result_value !== want.val)
          report_mismatch("result_value", result_bus.result_value, want.val);
        if (result_bus.stack_count !== want.cnt)
          report_mismatch("stack_count", sme_pkg::WORD_W'(result_bus.stack_count),
                          sme_pkg::WORD_W'(want.cnt));
      end
    end
  end

  // result sink with random back-pressure
  initial begin
    int unsigned stall;
    result_bus.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = draw_gap(recv_burst);
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (result_bus.valid !== 1'b1);
    end
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    step_result_t                typed_res;
    step_result_t                none;
    logic [sme_pkg::OP_W-1:0]    op;
    logic [sme_pkg::OP_W-1:0]    halt_op;
    logic [sme_pkg::OP_W-1:0]    other_halt_op;
    int unsigned                 target_depth;
    int unsigned                 episode_left;
    int unsigned                 pick;
    rst = 1'b1;
    instr_bus.valid      = 1'b0;
    instr_bus.operation  = sme_pkg::OP_READ;
    instr_bus.address    = '0;
    instr_bus.load_value = '0;
    error_count   = 0;
    send_burst    = 1'b0;
    recv_burst    = 1'b0;
    shadow_depth  = 0;
    shadow_halted = 1'b0;
    none          = '0;
    foreach (shadow_data[i]) shadow_data[i] = '0;
    foreach (shadow_stack[i]) shadow_stack[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      typed_res.st  = directed_rows[i].st;
      typed_res.val = directed_rows[i].val;
      typed_res.cnt = directed_rows[i].cnt;
      send_instruction(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].lval,
                       directed_rows[i].typed, typed_res);
    end

    // episodes steer the stack toward a target depth; the first one runs into overflow
    target_depth = N_STACK + 2;
    episode_left = N_STACK + 20;
    repeat (N_RANDOM) begin
      if (episode_left == 0) begin
        case ($urandom_range(0, 3))
          0: target_depth = 0;
          1: target_depth = $urandom_range(0, 8);
          2: target_depth = $urandom_range(0, N_STACK);
          default: target_depth = N_STACK;
        endcase
        episode_left = $urandom_range(10, 90);
      end
      episode_left--;
      pick = $urandom_range(0, 99);
      if (pick < 10) op = LIVE_OPS[$urandom_range(0, 5)];
      else if (pick < 24) op = sme_pkg::OP_LOAD;
      else if (pick < 30) op = sme_pkg::OP_READ;
      else if (shadow_depth < target_depth) op = sme_pkg::OP_PUSH;
      else if (shadow_depth > target_depth) op = SHRINK_OPS[$urandom_range(0, 2)];
      else op = LIVE_OPS[$urandom_range(0, 3)];
      send_instruction(op, draw_addr(), draw_word(), 1'b0, none);
    end

    // halt, then every operation while halted, then collect the data memory
    halt_op       = $urandom_range(0, 1) ? sme_pkg::OP_END : OP_UNDEFINED;
    other_halt_op = (halt_op == sme_pkg::OP_END) ? OP_UNDEFINED : sme_pkg::OP_END;
    send_instruction(halt_op, draw_addr(), draw_word(), 1'b0, none);
    send_instruction(other_halt_op, draw_addr(), draw_word(), 1'b0, none);
    foreach (LIVE_OPS[i]) send_instruction(LIVE_OPS[i], draw_addr(), draw_word(), 1'b0, none);
    for (int a = 0; a < N_DATA; a++)
      send_instruction(sme_pkg::OP_READ, sme_pkg::ADDR_W'(a), draw_word(), 1'b0, none);

    instr_bus.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/core/sme_pkg.sv
rtl/core/sme_if.sv
rtl/core/sme_ram.sv
rtl/core/sme_step.sv
rtl/core/stack_machine_execute.sv
dv/tb_stack_machine_execute.sv
